// ----- rtl/core/nau_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package nau_pkg;

  localparam int DataWidth = 16;
  localparam int ExpDepth = 256;
  localparam int ExpIdxW = 8;
  localparam int DotW = 40;
  localparam int LogitW = 24;
  localparam int SumW = 32;
  localparam int AccW = 40;
  localparam int QueueDepth = 2;
  localparam int NumColours = 3;
  localparam int DivSteps = 41;

  localparam logic [15:0] InvSqrtReset = 16'd16384;
  localparam logic [0:0] RegInvSqrt = 1'b0;

  // neighbor-end record handed from the front to the back
  typedef struct packed {
    logic signed [LogitW-1:0]    logit;
    logic signed [DataWidth-1:0] val_r;
    logic signed [DataWidth-1:0] val_g;
    logic signed [DataWidth-1:0] val_b;
    logic                        last_neighbor;
  } nbr_t;

  typedef logic [ExpDepth-1:0][15:0] exp_tab_t;

  // exp table in Q1.15: entry i = 2^(-i/256), as a 14-term series for exp(-z) in q2.30
  function automatic exp_tab_t build_exp_table();
    exp_tab_t tab;
    longint unsigned z, term;
    longint sum;
    for (int i = 0; i < ExpDepth; i++) begin
      z = (64'(i) * 64'd744261118) / 64'(ExpDepth);
      sum = 64'sd1073741824;
      term = 64'd1073741824;
      for (int n = 1; n <= 14; n++) begin
        term = ((term * z) >> 30) / 64'(n);
        if (n[0]) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      tab[i] = 16'((sum + 64'sd16384) >>> 15);
    end
    return tab;
  endfunction

  localparam exp_tab_t ExpTable = build_exp_table();

endpackage
`default_nettype wire

// ----- rtl/core/neighborhood_attention_upscale_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// channel   handshake               payload
// in        in_valid / in_ready     query, key, flags, bias, colour
// out       out_valid / out_ready   out_red, out_green, out_blue
// cfg       apb psel/penable        inv_sqrt_channels at address 0
//
// a channel beat passes through the front as a multiply, then an accumulate
// a last-channel beat is then scaled to a logit and pushed; the back runs the softmax update
// a last-neighbor beat adds a bit-serial divide per colour in the back
// synchronous active-low reset clears the per-pixel state and presets the scale register
// the queue lets the front take beats while the back updates or the output stalls
module neighborhood_attention_upscale_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] in_query_value,
  input  wire logic signed [15:0] in_key_value,
  input  wire logic               in_last_channel,
  input  wire logic               in_neighbor_inside,
  input  wire logic signed [15:0] in_bias,
  input  wire logic signed [15:0] in_value_red,
  input  wire logic signed [15:0] in_value_green,
  input  wire logic signed [15:0] in_value_blue,
  input  wire logic               in_last_neighbor,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      out_red,
  output logic signed [15:0]      out_green,
  output logic signed [15:0]      out_blue,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  logic [15:0] inv_sqrt_r;
  logic fq_valid, fq_ready, bq_valid, bq_ready;
  nau_pkg::nbr_t fq_data, bq_data;

  assign pready = 1'b1;
  // single register, decoded on the word index
  assign prdata = (paddr[2] == nau_pkg::RegInvSqrt) ? {16'd0, inv_sqrt_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) inv_sqrt_r <= nau_pkg::InvSqrtReset;
    else if (psel && penable && pwrite && paddr[2] == nau_pkg::RegInvSqrt && paddr[1:0] == 2'd0)
      inv_sqrt_r <= pwdata[15:0];
  end

  nau_front u_front (
    .clk, .rst_n, .in_valid, .in_ready,
    .query_value(in_query_value), .key_value(in_key_value),
    .last_channel(in_last_channel), .neighbor_inside(in_neighbor_inside),
    .bias(in_bias), .value_red(in_value_red), .value_green(in_value_green),
    .value_blue(in_value_blue), .last_neighbor(in_last_neighbor),
    .inv_sqrt(inv_sqrt_r),
    .q_valid(fq_valid), .q_ready(fq_ready), .q_data(fq_data)
  );

  nau_queue u_queue (
    .clk, .rst_n,
    .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_data),
    .rd_valid(bq_valid), .rd_ready(bq_ready), .rd_data(bq_data)
  );

  nau_back u_back (
    .clk, .rst_n,
    .q_valid(bq_valid), .q_ready(bq_ready), .q_data(bq_data),
    .out_valid, .out_ready, .out_red, .out_green, .out_blue
  );

endmodule
`default_nettype wire

// ----- rtl/core/nau_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module nau_front (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic signed [15:0]    query_value,
  input  wire logic signed [15:0]    key_value,
  input  wire logic                  last_channel,
  input  wire logic                  neighbor_inside,
  input  wire logic signed [15:0]    bias,
  input  wire logic signed [15:0]    value_red,
  input  wire logic signed [15:0]    value_green,
  input  wire logic signed [15:0]    value_blue,
  input  wire logic                  last_neighbor,
  input  wire logic [15:0]           inv_sqrt,
  output logic                       q_valid,
  input  wire logic                  q_ready,
  output nau_pkg::nbr_t              q_data
);

  typedef enum logic [1:0] {S_IDLE, S_PROD, S_SCALE, S_PUSH} state_t;

  state_t state_r;
  logic signed [nau_pkg::DotW-1:0] dot_r;
  logic signed [31:0] prod_r;
  logic signed [56:0] scaled_r;
  logic lc_r, ins_r, ln_r;
  logic signed [15:0] bias_r, vr_r, vg_r, vb_r;
  nau_pkg::nbr_t out_r;

  logic signed [nau_pkg::DotW:0] dsum;
  logic signed [nau_pkg::DotW-1:0] dsat;
  logic signed [56:0] rnd;
  logic signed [31:0] lg;
  logic signed [nau_pkg::LogitW-1:0] lsat;

  always_comb begin
    dsum = 41'(dot_r) + 41'(ins_r ? prod_r : 32'sd0);
    if (dsum > 41'sh7F_FFFF_FFFF) dsat = 40'sh7F_FFFF_FFFF;
    else if (dsum < -41'sh80_0000_0000) dsat = 40'sh80_0000_0000;
    else dsat = dsum[39:0];
    rnd = (scaled_r + 57'sd33554432) >>> 26;
    lg = (ins_r ? 32'(rnd) : 32'sd0) + 32'(bias_r);
    if (lg > 32'sh7F_FFFF) lsat = 24'sh7F_FFFF;
    else if (lg < -32'sh80_0000) lsat = 24'sh80_0000;
    else lsat = lg[23:0];
  end

  assign in_ready = (state_r == S_IDLE);
  assign q_valid = (state_r == S_PUSH);
  assign q_data = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      dot_r <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: if (in_valid) begin
          prod_r <= query_value * key_value;
          lc_r <= last_channel; ins_r <= neighbor_inside; ln_r <= last_neighbor;
          bias_r <= bias; vr_r <= value_red; vg_r <= value_green; vb_r <= value_blue;
          state_r <= S_PROD;
        end
        S_PROD: begin
          if (lc_r) begin
            scaled_r <= 57'(dsat) * $signed({1'b0, inv_sqrt});
            dot_r <= '0;
            state_r <= S_SCALE;
          end else begin
            dot_r <= dsat;
            state_r <= S_IDLE;
          end
        end
        S_SCALE: begin
          out_r.logit <= lsat;
          out_r.val_r <= ins_r ? vr_r : '0;
          out_r.val_g <= ins_r ? vg_r : '0;
          out_r.val_b <= ins_r ? vb_r : '0;
          out_r.last_neighbor <= ln_r;
          state_r <= S_PUSH;
        end
        S_PUSH: if (q_ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/nau_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
module nau_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          wr_valid,
  output logic               wr_ready,
  input  wire nau_pkg::nbr_t wr_data,
  output logic               rd_valid,
  input  wire logic          rd_ready,
  output nau_pkg::nbr_t      rd_data
);

  nau_pkg::nbr_t mem_r [nau_pkg::QueueDepth];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  logic do_wr, do_rd;

  assign wr_ready = (cnt_r != 2'(nau_pkg::QueueDepth));
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data = mem_r[rp_r];
  assign do_wr = wr_valid && wr_ready;
  assign do_rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wp_r] <= wr_data;
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= '0;
    end else begin
      if (do_wr) wp_r <= ~wp_r;
      if (do_rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(do_wr) - 2'(do_rd);
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/nau_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module nau_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_valid,
  output logic                    q_ready,
  input  wire nau_pkg::nbr_t      q_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      out_red,
  output logic signed [15:0]      out_green,
  output logic signed [15:0]      out_blue
);

  typedef enum logic [3:0] {
    S_IDLE, S_D1, S_U1, S_U2, S_E, S_MS, S_MC, S_UPD, S_DSETUP, S_DIV, S_DFIN, S_OUT
  } state_t;

  state_t state_r;
  nau_pkg::nbr_t it_r;
  logic signed [23:0] max_r, m_r;
  logic [31:0] sum_r;
  logic signed [39:0] acc_r [nau_pkg::NumColours];
  logic [24:0] dw_r, ds_r;
  logic [40:0] uw_r, us_r;
  logic [15:0] w_r, s_r;
  logic [47:0] ssum_r;
  logic signed [56:0] sacc_r [nau_pkg::NumColours];
  logic signed [32:0] wv_r [nau_pkg::NumColours];
  logic [1:0] col_r;
  logic [5:0] step_r;
  logic [40:0] rem_r;
  logic [40:0] quo_r;
  logic [40:0] mag_r;
  logic neg_r;
  logic signed [15:0] res_r [nau_pkg::NumColours];

  function automatic logic [15:0] expn(input logic [40:0] u);
    if (u[40:10] >= 31'd16) return 16'd0;
    return nau_pkg::ExpTable[u[9 -: nau_pkg::ExpIdxW]] >> u[13:10];
  endfunction

  logic signed [24:0] mx;
  logic [48:0] snew;
  logic [32:0] rsub;
  logic [40:0] trial;
  logic signed [41:0] anew;
  logic signed [57:0] ar;

  always_comb begin
    mx = (q_data.logit > max_r) ? 25'(q_data.logit) : 25'(max_r);
    snew = 49'(ssum_r) + 49'd16384;
    snew = (snew >> 15) + 49'(w_r);
    trial = {rem_r[39:0], mag_r[40]};
    rsub = 33'(trial) - 33'(sum_r);
    ar = 58'(sacc_r[col_r]) + 58'sd16384;
    anew = 42'(ar >>> 15) + 42'(wv_r[col_r]);
  end

  assign q_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_red = res_r[0];
  assign out_green = res_r[1];
  assign out_blue = res_r[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      max_r <= 24'sh80_0000;
      sum_r <= '0;
      for (int c = 0; c < nau_pkg::NumColours; c++) acc_r[c] <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: if (q_valid) begin
          it_r <= q_data;
          m_r <= mx[23:0];
          dw_r <= 25'(mx) - 25'(q_data.logit);
          ds_r <= 25'(mx) - 25'(max_r);
          state_r <= S_D1;
        end
        S_D1: begin
          uw_r <= 41'(dw_r) * 41'd47274;
          us_r <= 41'(ds_r) * 41'd47274;
          state_r <= S_U1;
        end
        S_U1: begin
          uw_r <= (uw_r + 41'd16384) >> 15;
          us_r <= (us_r + 41'd16384) >> 15;
          state_r <= S_U2;
        end
        S_U2: begin
          w_r <= expn(uw_r);
          s_r <= expn(us_r);
          state_r <= S_E;
        end
        S_E: begin
          ssum_r <= 48'(s_r) * 48'(sum_r);
          col_r <= '0;
          state_r <= S_MS;
        end
        S_MS: begin
          sacc_r[col_r] <= 57'(acc_r[col_r]) * $signed({1'b0, s_r});
          wv_r[col_r] <= $signed({1'b0, w_r}) *
            ((col_r == 2'd0) ? it_r.val_r : (col_r == 2'd1) ? it_r.val_g : it_r.val_b);
          state_r <= S_MC;
        end
        S_MC: begin
          if (col_r == 2'd2) state_r <= S_UPD;
          else begin col_r <= col_r + 2'd1; state_r <= S_MS; end
          if (col_r == 2'd0) sum_r <= (snew > 49'hFFFF_FFFF) ? 32'hFFFF_FFFF : snew[31:0];
        end
        S_UPD: begin
          if (anew > 42'sh7F_FFFF_FFFF) acc_r[col_r] <= 40'sh7F_FFFF_FFFF;
          else if (anew < -42'sh80_0000_0000) acc_r[col_r] <= 40'sh80_0000_0000;
          else acc_r[col_r] <= anew[39:0];
          if (col_r == 2'd0) begin
            max_r <= m_r;
            state_r <= it_r.last_neighbor ? S_DSETUP : S_IDLE;
          end else col_r <= col_r - 2'd1;
        end
        S_DSETUP: begin
          neg_r <= acc_r[col_r][39];
          mag_r <= 41'(acc_r[col_r][39] ? -41'(acc_r[col_r]) : 41'(acc_r[col_r]))
                   + 41'(sum_r >> 1);
          rem_r <= '0;
          quo_r <= '0;
          step_r <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          // restoring divide, one quotient bit a cycle
          if (!rsub[32]) begin
            rem_r <= 41'(rsub[31:0]);
            quo_r <= {quo_r[39:0], 1'b1};
          end else begin
            rem_r <= trial;
            quo_r <= {quo_r[39:0], 1'b0};
          end
          mag_r <= {mag_r[39:0], 1'b0};
          if (step_r == 6'(nau_pkg::DivSteps - 1)) state_r <= S_DFIN;
          else step_r <= step_r + 6'd1;
        end
        S_DFIN: begin
          if (sum_r == 32'd0) res_r[col_r] <= '0;
          else if (neg_r) res_r[col_r] <= (quo_r > 41'd32768) ? 16'sh8000 : -16'(quo_r);
          else res_r[col_r] <= (quo_r > 41'd32767) ? 16'sh7FFF : 16'(quo_r);
          if (col_r == 2'd2) state_r <= S_OUT;
          else begin col_r <= col_r + 2'd1; state_r <= S_DSETUP; end
        end
        S_OUT: if (out_ready) begin
          state_r <= S_IDLE;
          max_r <= 24'sh80_0000;
          sum_r <= '0;
          for (int c = 0; c < nau_pkg::NumColours; c++) acc_r[c] <= '0;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- tb/sv/neighborhood_attention_upscale_core_tb.sv -----
`timescale 1ns / 1ps
module neighborhood_attention_upscale_core_tb;

  // one weighted colour triple
  typedef struct {
    logic signed [15:0] red;
    logic signed [15:0] green;
    logic signed [15:0] blue;
  } colour_t;

  localparam int StallLimit = 5000;
  localparam int DrainCycles = 300;
  localparam int LongHold = 400;

  // softmax predictor plus the store of weighted colours still owed by the block
  class attn_scoreboard;
    logic [15:0] pow2_lut[nau_pkg::ExpDepth];
    longint dot_sum;
    longint run_max;
    longint unsigned wsum;
    longint col_acc[3];
    logic [15:0] inv_sqrt;
    colour_t owed[$];
    int errors;
    int beats;
    int pixels;
    int nbrs;

    function new();
      longint unsigned z, term;
      longint acc_q30;
      for (int i = 0; i < nau_pkg::ExpDepth; i++) begin
        // 2^(-i/depth) as a truncated series for exp(-z) in q2.30
        z = (longint'(i) * 64'd744261118) / nau_pkg::ExpDepth;
        acc_q30 = 64'sd1073741824;
        term = 64'd1073741824;
        for (int n = 1; n <= 14; n++) begin
          term = ((term * z) >> 30) / n;
          if (n % 2 == 1) acc_q30 -= longint'(term);
          else acc_q30 += longint'(term);
        end
        if (acc_q30 < 0) acc_q30 = 0;
        pow2_lut[i] = 16'((longint'(acc_q30) + 16384) >>> 15);
      end
      inv_sqrt = nau_pkg::InvSqrtReset;
      clear_pixel();
    endfunction

    function void clear_pixel();
      dot_sum = 0;
      run_max = -(64'sd1 <<< (nau_pkg::LogitW - 1));
      wsum = 0;
      for (int c = 0; c < 3; c++) col_acc[c] = 0;
    endfunction

    function longint clamp(longint v, int bits);
      longint hi, lo;
      hi = (64'sd1 <<< (bits - 1)) - 1;
      lo = -hi - 1;
      return v > hi ? hi : (v < lo ? lo : v);
    endfunction

    // e^(-d) for d in q.10, through the base-2 table
    function longint unsigned exp_down(longint d);
      longint unsigned u, whole, idx;
      if (d < 0) d = 0;
      u = (longint'(d) * 47274 + 16384) >> 15;
      whole = u >> 10;
      if (whole >= 16) return 0;
      idx = ((u & 1023) * nau_pkg::ExpDepth) >> 10;
      if (idx >= nau_pkg::ExpDepth) idx = nau_pkg::ExpDepth - 1;
      return longint'(pow2_lut[idx]) >> whole;
    endfunction

    function void note_input(logic signed [15:0] q, logic signed [15:0] k, logic lc,
                             logic nbr_in, logic signed [15:0] bias,
                             logic signed [15:0] vr, logic signed [15:0] vg,
                             logic signed [15:0] vb, logic ln);
      longint logit, m, vals[3], a;
      longint unsigned w, s, mag, qm;
      colour_t res;
      longint outq[3];
      beats++;
      if (nbr_in) dot_sum = clamp(dot_sum + longint'(q) * longint'(k), nau_pkg::DotW);
      if (!lc) return;
      nbrs++;
      logit = nbr_in ? (dot_sum * longint'({48'd0, inv_sqrt}) + (64'sd1 <<< 25)) >>> 26 : 0;
      logit = clamp(logit + longint'(bias), nau_pkg::LogitW);
      dot_sum = 0;
      m = logit > run_max ? logit : run_max;
      w = exp_down(m - logit);
      s = exp_down(m - run_max);
      vals[0] = nbr_in ? longint'(vr) : 0;
      vals[1] = nbr_in ? longint'(vg) : 0;
      vals[2] = nbr_in ? longint'(vb) : 0;
      wsum = ((s * wsum + 16384) >> 15) + w;
      if (wsum > 64'hFFFF_FFFF) wsum = 64'hFFFF_FFFF;
      for (int c = 0; c < 3; c++) begin
        a = (longint'(s) * col_acc[c] + 16384) >>> 15;
        col_acc[c] = clamp(a + longint'(w) * vals[c], nau_pkg::AccW);
      end
      run_max = m;
      if (!ln) return;
      for (int c = 0; c < 3; c++) begin
        outq[c] = 0;
        if (wsum != 0) begin
          mag = col_acc[c] < 0 ? longint'(-col_acc[c]) : longint'(col_acc[c]);
          qm = (mag + wsum / 2) / wsum;
          outq[c] = col_acc[c] < 0 ? -longint'(qm) : longint'(qm);
          outq[c] = clamp(outq[c], nau_pkg::DataWidth);
        end
      end
      res.red = 16'(outq[0]);
      res.green = 16'(outq[1]);
      res.blue = 16'(outq[2]);
      owed.push_back(res);
      pixels++;
      clear_pixel();
    endfunction

    task report(string what, longint got, longint want);
      $display("ERROR %0t %s: got %0d expected %0d", $realtime, what, got, want);
      errors++;
    endtask

    task check_result(logic signed [15:0] r, logic signed [15:0] g, logic signed [15:0] b);
      colour_t e;
      if (owed.size() == 0) begin
        report("unexpected out beat, red", r, 0);
        return;
      end
      e = owed.pop_front();
      if (r !== e.red) report("out_red", r, e.red);
      if (g !== e.green) report("out_green", g, e.green);
      if (b !== e.blue) report("out_blue", b, e.blue);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] in_query_value = '0;
  logic signed [15:0] in_key_value = '0;
  logic in_last_channel = 1'b0;
  logic in_neighbor_inside = 1'b0;
  logic signed [15:0] in_bias = '0;
  logic signed [15:0] in_value_red = '0;
  logic signed [15:0] in_value_green = '0;
  logic signed [15:0] in_value_blue = '0;
  logic in_last_neighbor = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] out_red;
  logic signed [15:0] out_green;
  logic signed [15:0] out_blue;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  attn_scoreboard sb = new();
  int idle_cycles = 0;
  int burst_left = 0;
  bit gaps_on = 1'b1;
  bit hold_req = 1'b0;
  int cfg_writes = 0;

  always #5 clk = ~clk;

  neighborhood_attention_upscale_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_query_value(in_query_value), .in_key_value(in_key_value),
    .in_last_channel(in_last_channel), .in_neighbor_inside(in_neighbor_inside),
    .in_bias(in_bias), .in_value_red(in_value_red), .in_value_green(in_value_green),
    .in_value_blue(in_value_blue), .in_last_neighbor(in_last_neighbor),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_red(out_red), .out_green(out_green), .out_blue(out_blue),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // result side: every accepted beat goes straight to the scoreboard
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_red, out_green, out_blue);
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("timeout after %0d quiet cycles", idle_cycles);
      $display("neighborhood_attention_upscale_core: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: runs of always-ready, coin-flip and mostly-stalled, plus a long hold on request
  initial begin
    int run_len, mode;
    @(posedge clk);
    wait (rst_n);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LongHold) @(posedge clk);
      end
      run_len = $urandom_range(1, 30);
      mode = $urandom_range(0, 2);
      repeat (run_len) begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= $urandom_range(0, 1);
          default: out_ready <= ($urandom_range(0, 5) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // half full-range random values, some small, some at the rails
  function automatic logic signed [15:0] pick16();
    case ($urandom_range(0, 7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2, 3: return 16'($signed($urandom_range(0, 4095)) - 2048);
      default: return 16'($urandom);
    endcase
  endfunction

  // offers one beat, honoring burst gaps, and returns at the edge that takes it
  task automatic send_beat(logic signed [15:0] q, logic signed [15:0] k, logic lc,
                           logic nbr_in, logic signed [15:0] bias, logic signed [15:0] vr,
                           logic signed [15:0] vg, logic signed [15:0] vb, logic ln);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = gaps_on ? $urandom_range(0, 8) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_query_value <= q;
    in_key_value <= k;
    in_last_channel <= lc;
    in_neighbor_inside <= nbr_in;
    in_bias <= bias;
    in_value_red <= vr;
    in_value_green <= vg;
    in_value_blue <= vb;
    in_last_neighbor <= ln;
    do @(posedge clk); while (!in_ready);
    sb.note_input(q, k, lc, nbr_in, bias, vr, vg, vb, ln);
  endtask

  // one window of random neighbors; now and then the inside flag flips within a neighbor
  task automatic send_pixel(int max_nbr, int max_ch);
    int n_nbr, n_ch;
    logic nbr_in, ins;
    n_nbr = $urandom_range(1, max_nbr);
    for (int n = 0; n < n_nbr; n++) begin
      n_ch = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 16) : $urandom_range(1, max_ch);
      nbr_in = ($urandom_range(0, 4) != 0);
      for (int c = 0; c < n_ch; c++) begin
        ins = ($urandom_range(0, 9) == 0) ? ~nbr_in : nbr_in;
        if (c == n_ch - 1) ins = nbr_in;
        send_beat(pick16(), pick16(), c == n_ch - 1, ins, pick16(), pick16(), pick16(),
                  pick16(), (c == n_ch - 1) ? (n == n_nbr - 1) : 1'($urandom_range(0, 1)));
      end
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
    // a last-channel beat with no result may still be in the softmax pipe
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic cfg_access(logic wr, logic [2:0] addr, logic [31:0] data,
                            output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // write the scale, poke an unmapped address, then read the scale back
  task automatic set_scale(logic [15:0] val);
    logic [31:0] rd;
    cfg_access(1'b1, 3'd0, {16'($urandom), val}, rd);
    sb.inv_sqrt = val;
    cfg_access(1'b1, 3'd4, $urandom, rd);
    cfg_access(1'b0, 3'd0, 32'd0, rd);
    if (rd[15:0] !== sb.inv_sqrt) sb.report("inv_sqrt_channels readback", rd[15:0], sb.inv_sqrt);
    cfg_writes++;
  endtask

  initial begin
    logic [15:0] scales[6];
    int target;
    bit hold_done, wait_done;
    scales = '{nau_pkg::InvSqrtReset, 16'd0, 16'hffff, 16'd1, 16'($urandom), 16'($urandom)};
    hold_done = 1'b0;
    wait_done = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: rails, outside neighbors, ignored fields on inner channels
    gaps_on = 1'b0;
    send_beat(16'sh7fff, 16'sh7fff, 1'b0, 1'b1, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1'b1);
    send_beat(16'sh7fff, 16'sh7fff, 1'b1, 1'b1, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh0000, 1'b0);
    send_beat(16'sh1234, 16'sh7fff, 1'b0, 1'b0, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0);
    send_beat(16'sh7fff, 16'sh1234, 1'b1, 1'b0, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0);
    send_beat(16'sh8000, 16'sh8000, 1'b0, 1'b1, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 1'b0);
    send_beat(16'sh8000, 16'sh7fff, 1'b1, 1'b1, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000, 1'b1);
    // window of only outside neighbors gives zero colour
    send_beat(16'sh7fff, 16'sh7fff, 1'b1, 1'b0, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0);
    send_beat(16'sh0000, 16'sh0000, 1'b1, 1'b0, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1'b1);
    // single inside neighbor: weight one, colour passes through
    send_beat(16'sh0400, 16'sh0400, 1'b1, 1'b1, 16'sh0000, 16'sh0400, 16'shfc00, 16'sh7fff, 1'b1);
    send_beat(16'sh0000, 16'sh0000, 1'b1, 1'b1, 16'sh7fff, 16'sh8000, 16'sh0001, 16'shffff, 1'b1);
    // two equal logits
    send_beat(16'sh0100, 16'sh0100, 1'b1, 1'b1, 16'sh0010, 16'sh0800, 16'sh0000, 16'sh8000, 1'b0);
    send_beat(16'sh0100, 16'sh0100, 1'b1, 1'b1, 16'sh0010, 16'sh0000, 16'sh0800, 16'sh7fff, 1'b1);
    gaps_on = 1'b1;

    for (int p = 0; p < 6; p++) begin
      drain();
      set_scale(scales[p]);
      target = sb.beats + 115;
      while (sb.beats < target) begin
        if (p == 2 && !hold_done && sb.beats > target - 80) begin
          // long receiver hold while the sender keeps the block full
          hold_done = 1'b1;
          hold_req = 1'b1;
          gaps_on = 1'b0;
        end
        if (p == 3 && !wait_done && sb.beats > target - 60) begin
          // sender waits for every owed result before carrying on
          wait_done = 1'b1;
          in_valid <= 1'b0;
          while (sb.owed.size() != 0) @(posedge clk);
        end
        send_pixel((p == 4) ? 2 : 9, 4);
        if (sb.beats > target - 30) gaps_on = 1'b1;
      end
    end
    drain();

    $display("run: %0d input beats, %0d neighbors, %0d pixels, %0d scale settings",
             sb.beats, sb.nbrs, sb.pixels, cfg_writes);
    $display("%0d mismatches logged", sb.errors);
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("neighborhood_attention_upscale_core: match");
    end else begin
      $display("neighborhood_attention_upscale_core: mismatch");
    end
    $finish;
  end

endmodule
